### src/arfe_pkg.sv
// Shared types and constants for the alpha rectangle fill engine.
package arfe_pkg;

  localparam int unsigned ScreenWidthDef  = 800;
  localparam int unsigned ScreenHeightDef = 600;

  localparam int unsigned PosW   = 12;
  localparam int unsigned SizeW  = 12;
  localparam int unsigned SumW   = 14;
  localparam int unsigned PixW   = 32;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned TouchW = 19;

  localparam logic [TouchW-1:0] TouchMax    = '1;
  localparam logic [ChanW-1:0]  AlphaOpaque = 8'hFF;
  localparam logic [ChanW-1:0]  AlphaClear  = 8'h00;
  localparam logic [PixW-1:0]   OpaqueMask  = 32'hFF000000;

  typedef enum logic {
    FUNC_FILL = 1'b0,
    FUNC_READ = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    CHAN_B = 2'd0,
    CHAN_G = 2'd1,
    CHAN_R = 2'd2
  } chan_e;

  typedef enum logic [3:0] {
    ST_CLEAR   = 4'd0,
    ST_IDLE    = 4'd1,
    ST_SETUP   = 4'd2,
    ST_BASE    = 4'd3,
    ST_READ    = 4'd4,
    ST_CAPTURE = 4'd5,
    ST_BLEND_R = 4'd6,
    ST_BLEND_G = 4'd7,
    ST_WRITE   = 4'd8,
    ST_FINISH  = 4'd9
  } state_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

### src/arfe_mem.sv
// Single-port frame store with registered read data.
module arfe_mem #(
  parameter int unsigned Depth = arfe_pkg::ScreenWidthDef * arfe_pkg::ScreenHeightDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                       clk_i,
  input  arfe_pkg::mem_ctl_t         ctl_i,
  input  logic [AddrW-1:0]           addr_i,
  input  logic [arfe_pkg::PixW-1:0]  wdata_i,
  output logic [arfe_pkg::PixW-1:0]  rdata_o
);
  import arfe_pkg::*;

  logic [PixW-1:0] mem_q [Depth];
  logic [PixW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/arfe_blend.sv
// Shared one-channel alpha blend unit.
module arfe_blend (
  input  logic [arfe_pkg::PixW-1:0]  color_i,
  input  logic [arfe_pkg::PixW-1:0]  bg_i,
  input  arfe_pkg::chan_e            chan_i,
  output logic [arfe_pkg::ChanW-1:0] val_o
);
  import arfe_pkg::*;

  logic [ChanW-1:0]   alpha;
  logic [ChanW-1:0]   inv;
  logic [ChanW-1:0]   fg_c;
  logic [ChanW-1:0]   bg_c;
  logic [2*ChanW-1:0] prod_fg;
  logic [2*ChanW-1:0] prod_bg;
  logic [2*ChanW-1:0] mix;

  always_comb begin
    alpha = color_i[PixW-1 -: ChanW];
    inv   = AlphaOpaque - alpha;
    case (chan_i)
      CHAN_R: begin
        fg_c = color_i[3*ChanW-1 -: ChanW];
        bg_c = bg_i[3*ChanW-1 -: ChanW];
      end
      CHAN_G: begin
        fg_c = color_i[2*ChanW-1 -: ChanW];
        bg_c = bg_i[2*ChanW-1 -: ChanW];
      end
      CHAN_B: begin
        fg_c = color_i[ChanW-1:0];
        bg_c = bg_i[ChanW-1:0];
      end
      default: begin
        fg_c = '0;
        bg_c = '0;
      end
    endcase
    prod_fg = fg_c * alpha;
    prod_bg = bg_c * inv;
    mix     = prod_fg + prod_bg;
  end

  assign val_o = mix[2*ChanW-1 -: ChanW];

endmodule

### src/arfe_ctrl.sv
// Sequencer: clipping, pixel walk, read-modify-write and result register.
module arfe_ctrl #(
  parameter int unsigned ScreenWidth  = arfe_pkg::ScreenWidthDef,
  parameter int unsigned ScreenHeight = arfe_pkg::ScreenHeightDef,
  parameter int unsigned Depth        = ScreenWidth * ScreenHeight,
  parameter int unsigned AddrW        = $clog2(Depth)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              func_i,
  input  logic signed [arfe_pkg::PosW-1:0]  pos_x_i,
  input  logic signed [arfe_pkg::PosW-1:0]  pos_y_i,
  input  logic [arfe_pkg::SizeW-1:0]        rect_width_i,
  input  logic [arfe_pkg::SizeW-1:0]        rect_height_i,
  input  logic [arfe_pkg::PixW-1:0]         fill_color_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [arfe_pkg::PixW-1:0]         pixel_value_o,
  output logic [arfe_pkg::TouchW-1:0]       pixels_touched_o,
  output logic                              off_screen_o,
  output arfe_pkg::mem_ctl_t                mem_ctl_o,
  output logic [AddrW-1:0]                  mem_addr_o,
  output logic [arfe_pkg::PixW-1:0]         mem_wdata_o,
  input  logic [arfe_pkg::PixW-1:0]         mem_rdata_i,
  output arfe_pkg::chan_e                   chan_o,
  input  logic [arfe_pkg::ChanW-1:0]        blend_i
);
  import arfe_pkg::*;

  localparam int unsigned XW = $clog2(ScreenWidth + 1);
  localparam int unsigned YW = $clog2(ScreenHeight + 1);
  localparam logic signed [SumW-1:0] ScrW = SumW'(ScreenWidth);
  localparam logic signed [SumW-1:0] ScrH = SumW'(ScreenHeight);
  localparam logic [AddrW-1:0] RowStep  = AddrW'(ScreenWidth);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  state_e state_q, state_d;

  func_e                   func_q;
  logic signed [PosW-1:0]  pos_x_q;
  logic signed [PosW-1:0]  pos_y_q;
  logic [SizeW-1:0]        width_q;
  logic [SizeW-1:0]        height_q;
  logic [PixW-1:0]         color_q;

  logic [XW-1:0]    x0_q, x1_q, x_q;
  logic [YW-1:0]    y1_q, y_q;
  logic [AddrW-1:0] base_q;
  logic [AddrW-1:0] clr_q;
  logic [TouchW-1:0] cnt_q;
  logic [ChanW-1:0] red_q, grn_q;
  logic [PixW-1:0]  res_pixel_q;
  logic             res_off_q;

  logic              out_valid_q;
  logic [PixW-1:0]   out_pixel_q;
  logic [TouchW-1:0] out_touch_q;
  logic              out_off_q;

  logic signed [SumW-1:0] sx, sy, ex, ey;
  logic off_fill, off_read, empty, setup_done;
  logic [XW-1:0] x0_c, x1_c, x_nxt;
  logic [YW-1:0] y0_c, y1_c, y_nxt;
  logic last_x, last_y, out_free;
  logic [ChanW-1:0] alpha;

  always_comb begin
    sx = SumW'(pos_x_q);
    sy = SumW'(pos_y_q);
    ex = sx + SumW'(width_q);
    ey = sy + SumW'(height_q);
    off_fill = (sx >= ScrW) || (sy >= ScrH) || ex[SumW-1] || (ex == '0) ||
               ey[SumW-1] || (ey == '0);
    off_read = sx[SumW-1] || sy[SumW-1] || (sx >= ScrW) || (sy >= ScrH);
    empty    = (width_q == '0) || (height_q == '0);
    x0_c = sx[SumW-1] ? '0 : sx[XW-1:0];
    y0_c = sy[SumW-1] ? '0 : sy[YW-1:0];
    x1_c = (ex > ScrW) ? XW'(ScreenWidth) : ex[XW-1:0];
    y1_c = (ey > ScrH) ? YW'(ScreenHeight) : ey[YW-1:0];
    setup_done = (func_q == FUNC_READ) ? off_read : (off_fill || empty);
  end

  assign x_nxt    = XW'(x_q + 1'b1);
  assign y_nxt    = YW'(y_q + 1'b1);
  assign last_x   = (x_nxt == x1_q);
  assign last_y   = (y_nxt == y1_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign alpha    = color_q[PixW-1 -: ChanW];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == LastAddr) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP:   state_d = setup_done ? ST_FINISH : ST_BASE;
      ST_BASE:    state_d = ST_READ;
      ST_READ:    state_d = (func_q == FUNC_READ) ? ST_CAPTURE : ST_BLEND_R;
      ST_CAPTURE: state_d = ST_FINISH;
      ST_BLEND_R: state_d = ST_BLEND_G;
      ST_BLEND_G: state_d = ST_WRITE;
      ST_WRITE:   state_d = (last_x && last_y) ? ST_FINISH : ST_READ;
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    mem_ctl_o.wr_en = 1'b0;
    mem_ctl_o.rd_en = 1'b0;
    chan_o          = CHAN_B;
    case (state_q)
      ST_CLEAR:   mem_ctl_o.wr_en = 1'b1;
      ST_IDLE:    in_ready_o = 1'b1;
      ST_READ:    mem_ctl_o.rd_en = 1'b1;
      ST_BLEND_R: chan_o = CHAN_R;
      ST_BLEND_G: chan_o = CHAN_G;
      ST_WRITE:   mem_ctl_o.wr_en = 1'b1;
      default:    chan_o = CHAN_B;
    endcase
  end

  always_comb begin
    mem_addr_o = (state_q == ST_CLEAR) ? clr_q : AddrW'(base_q + AddrW'(x_q));
    if (state_q == ST_CLEAR) begin
      mem_wdata_o = '0;
    end else if (alpha == AlphaOpaque) begin
      mem_wdata_o = color_q;
    end else if (alpha == AlphaClear) begin
      mem_wdata_o = mem_rdata_i;
    end else begin
      mem_wdata_o = OpaqueMask | {AlphaClear, red_q, grn_q, blend_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= AddrW'(clr_q + 1'b1);
      end
      if (state_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      func_q   <= func_e'(func_i);
      pos_x_q  <= pos_x_i;
      pos_y_q  <= pos_y_i;
      width_q  <= rect_width_i;
      height_q <= rect_height_i;
      color_q  <= fill_color_i;
    end
    case (state_q)
      ST_SETUP: begin
        x0_q        <= x0_c;
        x1_q        <= x1_c;
        x_q         <= x0_c;
        y_q         <= y0_c;
        y1_q        <= y1_c;
        cnt_q       <= '0;
        res_pixel_q <= '0;
        res_off_q   <= (func_q == FUNC_READ) ? off_read : off_fill;
      end
      ST_BASE:    base_q <= AddrW'(y_q) * RowStep;
      ST_CAPTURE: res_pixel_q <= mem_rdata_i;
      ST_BLEND_R: red_q <= blend_i;
      ST_BLEND_G: grn_q <= blend_i;
      ST_WRITE: begin
        if (cnt_q != TouchMax) begin
          cnt_q <= TouchW'(cnt_q + 1'b1);
        end
        if (last_x) begin
          x_q    <= x0_q;
          y_q    <= y_nxt;
          base_q <= AddrW'(base_q + RowStep);
        end else begin
          x_q <= x_nxt;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_pixel_q <= res_pixel_q;
          out_touch_q <= cnt_q;
          out_off_q   <= res_off_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign pixel_value_o    = out_pixel_q;
  assign pixels_touched_o = out_touch_q;
  assign off_screen_o     = out_off_q;

  a_mem_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_ctl_o.wr_en && mem_ctl_o.rd_en))
    else $error("frame store read and written in one cycle");

  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_ctl_o.wr_en || mem_ctl_o.rd_en) |-> ({1'b0, mem_addr_o} < (AddrW+1)'(Depth)))
    else $error("frame store address beyond screen");

  a_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |-> ((x_q >= x0_q) && (x_q < x1_q)))
    else $error("pixel column outside clipped span");

  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_SETUP))
    else $error("accepted transaction did not start setup");

  a_finish_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && out_valid_q && !out_ready_i) |=> (state_q == ST_FINISH))
    else $error("result dropped while output register full");

endmodule

### src/alpha_rect_fill_engine_top.sv
// Top level of the alpha rectangle fill engine.
// Steps: read is setup, base, read, capture; fill is setup, base, then per clipped pixel
// (read, blend red, blend green, blend blue with write); off-screen or empty skip to finish.
// Throughput: one transaction at a time, set by the single-port store read-modify-write;
// in_ready_o returns as the result register loads, and that load waits while it is full.
// Reset: a clearing pass zeroes all pixels, one per cycle (480000 by default), ready low.
module alpha_rect_fill_engine_top #(
  parameter int unsigned ScreenWidth  = arfe_pkg::ScreenWidthDef,
  parameter int unsigned ScreenHeight = arfe_pkg::ScreenHeightDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              func_i,
  input  logic signed [arfe_pkg::PosW-1:0]  pos_x_i,
  input  logic signed [arfe_pkg::PosW-1:0]  pos_y_i,
  input  logic [arfe_pkg::SizeW-1:0]        rect_width_i,
  input  logic [arfe_pkg::SizeW-1:0]        rect_height_i,
  input  logic [arfe_pkg::PixW-1:0]         fill_color_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [arfe_pkg::PixW-1:0]         pixel_value_o,
  output logic [arfe_pkg::TouchW-1:0]       pixels_touched_o,
  output logic                              off_screen_o
);
  import arfe_pkg::*;

  localparam int unsigned Depth = ScreenWidth * ScreenHeight;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  mem_ctl_t         mem_ctl;
  logic [AddrW-1:0] mem_addr;
  logic [PixW-1:0]  mem_wdata;
  logic [PixW-1:0]  mem_rdata;
  chan_e            chan;
  logic [ChanW-1:0] blend_val;
  logic [PixW-1:0]  color_hold;

  arfe_ctrl #(
    .ScreenWidth  (ScreenWidth),
    .ScreenHeight (ScreenHeight),
    .Depth        (Depth),
    .AddrW        (AddrW)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .func_i           (func_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .rect_width_i     (rect_width_i),
    .rect_height_i    (rect_height_i),
    .fill_color_i     (fill_color_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .pixel_value_o    (pixel_value_o),
    .pixels_touched_o (pixels_touched_o),
    .off_screen_o     (off_screen_o),
    .mem_ctl_o        (mem_ctl),
    .mem_addr_o       (mem_addr),
    .mem_wdata_o      (mem_wdata),
    .mem_rdata_i      (mem_rdata),
    .chan_o           (chan),
    .blend_i          (blend_val)
  );

  arfe_mem #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      color_hold <= fill_color_i;
    end
  end

  arfe_blend u_blend (
    .color_i (color_hold),
    .bg_i    (mem_rdata),
    .chan_i  (chan),
    .val_o   (blend_val)
  );

endmodule
